>>> rtl/mmb3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmb3_pkg
// Shared types and constants for the 3x3 RGB median/mean blend filter.
// ----------------------------------------------------------------------------
package mmb3_pkg;

    localparam int unsigned CELLS       = 9;
    localparam int unsigned CH_W        = 8;
    localparam int unsigned WPR_W       = 9;
    localparam int unsigned WIN_IDX_W   = 8;
    localparam int unsigned FILL_W      = 4;
    // windows_per_row bounds
    localparam logic [WPR_W-1:0] WPR_MIN = 9'd1;
    localparam logic [WPR_W-1:0] WPR_MAX = 9'd256;
    // floor(x / 10) = (x * RECIP_10) >> RECIP_SH for x below 2^15
    localparam int unsigned RECIP_W  = 16;
    localparam logic [RECIP_W-1:0] RECIP_10 = 16'd52429;
    localparam int unsigned RECIP_SH = 19;

    // Input beat: one RGB pixel
    typedef struct packed {
        logic [CH_W-1:0] blue_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] red_in;
    } t_pix_in;

    // Output beat: one filtered RGB pixel
    typedef struct packed {
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] red_out;
    } t_pix_out;

    // One window cell: red [7:0], green [15:8], blue [23:16]
    typedef logic [3*CH_W-1:0] t_cell;
    // Complete window, row-major
    typedef t_cell [CELLS-1:0] t_win;

    // Window handed from front end to queue and from queue to back end
    typedef struct packed {
        logic vld;
        t_win win;
    } t_win_beat;

    // Queue status seen by the top level
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Front-end status, for checking
    typedef struct packed {
        logic              load_full;
        logic [FILL_W-1:0] fill;
    } t_fe_stat;

endpackage

>>> rtl/median_mean_blend_3x3_rgb_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_mean_blend_3x3_rgb_core
// 3x3 RGB median/mean blend: per channel (eight neighbours + 2 x median) / 10
// over a sliding window, refilled in full at the start of each row.
// ----------------------------------------------------------------------------
//  channel   signals                             direction
//  pixel in  i_in_valid / o_in_ready / i_in_data  sink, valid-ready
//  pixel out o_out_valid / i_out_ready / o_out_data  source, valid-ready
//  config    i_cfg_we / i_cfg_wdata               write only, no wait
//
//  One pixel beat per cycle is taken while the window queue has room; a row
//  costs nine beats for its first window and three for each one after.
//  A completed window passes through the queue and then the five-stage blend
//  pipeline (one window a cycle unless the output stalls).
//  Reset (synchronous, active low) empties the queue and pipeline, restarts
//  the row and sets windows_per_row to 256. An output stall halts the
//  pipeline; the queue then fills and input ready drops.
// ----------------------------------------------------------------------------
module median_mean_blend_3x3_rgb_core #(
    parameter int unsigned P_Q_DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  mmb3_pkg::t_pix_in          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output mmb3_pkg::t_pix_out         o_out_data,
    input  logic                       i_cfg_we,
    input  logic [mmb3_pkg::WPR_W-1:0] i_cfg_wdata
);

    logic [mmb3_pkg::WPR_W-1:0] r_wpr;
    logic                       in_acc;
    logic                       pop;
    mmb3_pkg::t_win_beat        push, head;
    mmb3_pkg::t_q_stat          q_stat;
    mmb3_pkg::t_fe_stat         fe_stat;

    // Row length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpr <= mmb3_pkg::WPR_MAX;
        end else if (i_cfg_we) begin
            r_wpr <= i_cfg_wdata;
        end
    end

    assign o_in_ready = !q_stat.full;
    assign in_acc     = i_in_valid && o_in_ready;

    mmb3_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_pix    (i_in_data),
        .i_wpr    (r_wpr),
        .o_push   (push),
        .o_stat   (fe_stat)
    );

    mmb3_queue #(
        .P_DEPTH (P_Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    mmb3_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    // Checks
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fe_stat.load_full || (fe_stat.fill < 4'd3))
        else $error("fill count past right column");

    a_fill_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fe_stat.fill < 4'd9)
        else $error("fill count past window size");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.vld |-> !q_stat.full)
        else $error("window pushed into full queue");

    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue both full and empty");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

endmodule

>>> rtl/mmb3_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmb3_front
// Window builder: takes pixels, maintains the 3x3 window and row position,
// and hands every completed window on to the queue.
// ----------------------------------------------------------------------------
module mmb3_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  mmb3_pkg::t_pix_in       i_pix,
    input  logic [mmb3_pkg::WPR_W-1:0] i_wpr,
    output mmb3_pkg::t_win_beat     o_push,
    output mmb3_pkg::t_fe_stat      o_stat
);

    mmb3_pkg::t_win                       r_cells, n_cells, n_cells_upd, n_cells_sh;
    logic [mmb3_pkg::FILL_W-1:0]          r_fill, n_fill;
    logic [mmb3_pkg::WIN_IDX_W-1:0]       r_wi, n_wi;
    logic                                 load_full;
    logic                                 complete;
    logic [3:0]                           wr_idx;
    logic [mmb3_pkg::WPR_W-1:0]           limit;
    logic [mmb3_pkg::WPR_W-1:0]           wi_inc;
    logic [mmb3_pkg::WIN_IDX_W-1:0]       wi_next;
    mmb3_pkg::t_cell                      px;

    assign px        = {i_pix.blue_in, i_pix.green_in, i_pix.red_in};
    assign load_full = (r_wi == '0);

    // Write slot: row-major during a full load, right column otherwise
    always_comb begin
        case (r_fill[1:0])
            2'd0:    wr_idx = 4'd2;
            2'd1:    wr_idx = 4'd5;
            default: wr_idx = 4'd8;
        endcase
        if (load_full) begin
            wr_idx = r_fill;
        end
    end

    assign complete = load_full ? (r_fill == 4'd8) : (r_fill == 4'd2);

    // Clamp the row length into its legal range
    always_comb begin
        if (i_wpr < mmb3_pkg::WPR_MIN) begin
            limit = mmb3_pkg::WPR_MIN;
        end else if (i_wpr > mmb3_pkg::WPR_MAX) begin
            limit = mmb3_pkg::WPR_MAX;
        end else begin
            limit = i_wpr;
        end
    end

    assign wi_inc  = {1'b0, r_wi} + 9'd1;
    assign wi_next = (wi_inc >= limit) ? '0 : wi_inc[mmb3_pkg::WIN_IDX_W-1:0];

    // Window with the new pixel written in
    always_comb begin
        n_cells_upd = r_cells;
        n_cells_upd[wr_idx] = px;
    end

    // Window moved one column left; right column keeps its old pixels
    always_comb begin
        n_cells_sh = n_cells_upd;
        for (int r = 0; r < 3; r++) begin
            n_cells_sh[r*3]     = n_cells_upd[r*3 + 1];
            n_cells_sh[r*3 + 1] = n_cells_upd[r*3 + 2];
        end
    end

    // Next state
    always_comb begin
        n_cells = r_cells;
        n_fill  = r_fill;
        n_wi    = r_wi;
        if (i_accept) begin
            if (complete) begin
                n_fill  = '0;
                n_wi    = wi_next;
                n_cells = (wi_next != '0) ? n_cells_sh : n_cells_upd;
            end else begin
                n_fill  = r_fill + 4'd1;
                n_cells = n_cells_upd;
            end
        end
    end

    // Window contents need no reset: a full load precedes every result
    always_ff @(posedge i_clk) begin
        r_cells <= n_cells;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_wi   <= '0;
        end else begin
            r_fill <= n_fill;
            r_wi   <= n_wi;
        end
    end

    assign o_push.vld = i_accept && complete;
    assign o_push.win = n_cells_upd;

    assign o_stat.load_full = load_full;
    assign o_stat.fill      = r_fill;

endmodule

>>> rtl/mmb3_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmb3_queue
// Short FIFO of completed windows between the front and back ends.
// ----------------------------------------------------------------------------
module mmb3_queue #(
    parameter int unsigned P_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mmb3_pkg::t_win_beat i_push,
    input  logic                i_pop,
    output mmb3_pkg::t_win_beat o_head,
    output mmb3_pkg::t_q_stat   o_stat
);

    localparam int unsigned PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(P_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(P_DEPTH);

    mmb3_pkg::t_win             r_mem [P_DEPTH];
    logic [PTR_W-1:0]           r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic                       do_push, do_pop;

    assign do_push = i_push.vld && (r_cnt != CNT_FULL);
    assign do_pop  = i_pop && (r_cnt != '0);

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.win;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    assign o_head.vld   = (r_cnt != '0);
    assign o_head.win   = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_cnt == CNT_FULL);
    assign o_stat.empty = (r_cnt == '0);

endmodule

>>> rtl/mmb3_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmb3_back
// Blend pipeline: per channel, median of nine by row sorts and a med-of-3
// reduction, neighbour sum, and divide by ten through a reciprocal multiply.
// Five stages, the last one the output register; stalls as a whole.
// ----------------------------------------------------------------------------
module mmb3_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mmb3_pkg::t_win_beat i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output mmb3_pkg::t_pix_out  o_data
);

    localparam int unsigned W    = mmb3_pkg::CH_W;
    localparam int unsigned SUMW = 11;   // eight 8-bit cells
    localparam int unsigned TOTW = 12;   // plus twice the median
    localparam int unsigned PRDW = TOTW + mmb3_pkg::RECIP_W;

    function automatic logic [W-1:0] f_min(input logic [W-1:0] a, input logic [W-1:0] b);
        f_min = (a < b) ? a : b;
    endfunction

    function automatic logic [W-1:0] f_max(input logic [W-1:0] a, input logic [W-1:0] b);
        f_max = (a < b) ? b : a;
    endfunction

    function automatic logic [W-1:0] f_med3(input logic [W-1:0] a, input logic [W-1:0] b,
                                            input logic [W-1:0] c);
        f_med3 = f_max(f_min(a, b), f_min(f_max(a, b), c));
    endfunction

    logic       en;
    logic [5:1] r_v;

    // Whole pipe advances unless a result waits at the output
    assign en    = !r_v[5] || i_ready;
    assign o_pop = en && i_head.vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[4:1], i_head.vld};
        end
    end

    logic [2:0][W-1:0] out_ch;

    for (genvar ch = 0; ch < 3; ch++) begin : g_ch
        logic [mmb3_pkg::CELLS-1:0][W-1:0] v;
        logic [2:0][W-1:0]  r1_lo, r1_md, r1_hi;
        logic [SUMW-1:0]    r1_sum, n1_sum;
        logic [W-1:0]       r2_lo, r2_md, r2_hi;
        logic [SUMW-1:0]    r2_sum;
        logic [TOTW-1:0]    r3_tot;
        logic [PRDW-1:0]    r4_prd;
        logic [W-1:0]       r5_out;
        logic [W-1:0]       med;

        always_comb begin
            for (int i = 0; i < mmb3_pkg::CELLS; i++) begin
                v[i] = i_head.win[i][ch*W +: W];
            end
            n1_sum = '0;
            for (int i = 0; i < mmb3_pkg::CELLS; i++) begin
                if (i != 4) begin
                    n1_sum = n1_sum + SUMW'(v[i]);
                end
            end
        end

        assign med = f_med3(r2_lo, r2_md, r2_hi);

        always_ff @(posedge i_clk) begin
            if (en) begin
                // stage 1: sort each row, sum the neighbours
                for (int r = 0; r < 3; r++) begin
                    r1_lo[r] <= f_min(f_min(v[r*3], v[r*3+1]), v[r*3+2]);
                    r1_md[r] <= f_med3(v[r*3], v[r*3+1], v[r*3+2]);
                    r1_hi[r] <= f_max(f_max(v[r*3], v[r*3+1]), v[r*3+2]);
                end
                r1_sum <= n1_sum;
                // stage 2: max of lows, median of mids, min of highs
                r2_lo  <= f_max(f_max(r1_lo[0], r1_lo[1]), r1_lo[2]);
                r2_md  <= f_med3(r1_md[0], r1_md[1], r1_md[2]);
                r2_hi  <= f_min(f_min(r1_hi[0], r1_hi[1]), r1_hi[2]);
                r2_sum <= r1_sum;
                // stage 3: median of nine, blended total
                r3_tot <= TOTW'(r2_sum) + TOTW'({med, 1'b0});
                // stage 4: reciprocal multiply
                r4_prd <= PRDW'(r3_tot) * PRDW'(mmb3_pkg::RECIP_10);
                // stage 5: output register
                r5_out <= r4_prd[mmb3_pkg::RECIP_SH +: W];
            end
        end

        assign out_ch[ch] = r5_out;
    end

    assign o_valid          = r_v[5];
    assign o_data.red_out   = out_ch[0];
    assign o_data.green_out = out_ch[1];
    assign o_data.blue_out  = out_ch[2];

endmodule

>>> verif/mmb3_blend_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmb3_blend_checker
// Watches the pixel channels of the 3x3 RGB median/mean blend core, keeps
// its own copy of the window, row position and windows_per_row, predicts
// each filtered pixel and compares it with the output beats in order.
// ----------------------------------------------------------------------------
module mmb3_blend_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  mmb3_pkg::t_pix_in          i_in_data,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  mmb3_pkg::t_pix_out         i_out_data,
    input  logic                       i_cfg_we,
    input  logic [mmb3_pkg::WPR_W-1:0] i_cfg_wdata,
    output int unsigned                o_fail_count,
    output int unsigned                o_pending
);

    localparam int unsigned CELLS      = mmb3_pkg::CELLS;
    localparam int unsigned CH_W       = mmb3_pkg::CH_W;
    localparam int unsigned DIVISOR    = 10;
    localparam int unsigned MAX_REPORT = 10;
    localparam int unsigned RED_SH     = 0;
    localparam int unsigned GREEN_SH   = 8;
    localparam int unsigned BLUE_SH    = 16;

    // Shadow of the filter state
    mmb3_pkg::t_win             window;
    int unsigned                fill;
    int unsigned                win_idx;
    logic [mmb3_pkg::WPR_W-1:0] row_windows;

    // Filtered pixels still to come out, oldest first
    mmb3_pkg::t_pix_out filtered_q[$];

    // Neighbour sum plus twice the median, over ten, for one channel
    function automatic logic [CH_W-1:0] channel_blend(mmb3_pkg::t_win w, int unsigned sh);
        logic [CH_W-1:0] v[CELLS];
        logic [CH_W-1:0] x;
        int unsigned     acc;
        int              i;
        int              j;
        for (i = 0; i < CELLS; i++) begin
            v[i] = w[i][sh +: CH_W];
        end
        // insertion sort, median lands in the middle slot
        for (i = 1; i < CELLS; i++) begin
            x = v[i];
            j = i;
            while (j > 0 && v[j-1] > x) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = x;
        end
        acc = 0;
        for (i = 0; i < CELLS; i++) begin
            if (i != CELLS / 2) begin
                acc += w[i][sh +: CH_W];
            end
        end
        acc += 2 * v[CELLS/2];
        return CH_W'(acc / DIVISOR);
    endfunction

    // Take one pixel into the window; queue a result when a window completes
    task automatic take_pixel(mmb3_pkg::t_pix_in px);
        mmb3_pkg::t_cell    c;
        mmb3_pkg::t_pix_out r;
        int unsigned        need;
        int unsigned        limit;
        int unsigned        nxt;
        int unsigned        row;
        c    = {px.blue_in, px.green_in, px.red_in};
        need = (win_idx == 0) ? CELLS : 3;
        if (win_idx == 0) begin
            window[fill % CELLS] = c;
        end else begin
            window[(fill % 3) * 3 + 2] = c;
        end
        fill++;
        if (fill < need) begin
            return;
        end
        r.red_out   = channel_blend(window, RED_SH);
        r.green_out = channel_blend(window, GREEN_SH);
        r.blue_out  = channel_blend(window, BLUE_SH);
        filtered_q.push_back(r);
        fill = 0;
        // out-of-range limits are clamped; a lowered limit ends the row here
        limit = row_windows;
        if (limit < mmb3_pkg::WPR_MIN) begin
            limit = mmb3_pkg::WPR_MIN;
        end
        if (limit > mmb3_pkg::WPR_MAX) begin
            limit = mmb3_pkg::WPR_MAX;
        end
        nxt = win_idx + 1;
        if (nxt >= limit) begin
            nxt = 0;
        end
        win_idx = nxt % 256;
        // slide left; right column stays stale until refilled
        if (win_idx != 0) begin
            for (row = 0; row < 3; row++) begin
                window[row*3]     = window[row*3 + 1];
                window[row*3 + 1] = window[row*3 + 2];
            end
        end
    endtask

    // Report a failed output beat, quietly once the first few are shown
    task automatic note_failure(string what, mmb3_pkg::t_pix_out exp_px,
                                mmb3_pkg::t_pix_out got_px);
        o_fail_count++;
        if (o_fail_count <= MAX_REPORT) begin
            $display("%0t %s: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     $realtime, what, exp_px.red_out, exp_px.green_out, exp_px.blue_out,
                     got_px.red_out, got_px.green_out, got_px.blue_out);
        end
    endtask

    // Sample both channels and the register port on every rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            window       = '0;
            fill         = 0;
            win_idx      = 0;
            row_windows  = mmb3_pkg::WPR_MAX;
            o_fail_count = 0;
            filtered_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (filtered_q.size() == 0) begin
                    note_failure("unexpected beat", '0, i_out_data);
                end else if (i_out_data.red_out   !== filtered_q[0].red_out   ||
                             i_out_data.green_out !== filtered_q[0].green_out ||
                             i_out_data.blue_out  !== filtered_q[0].blue_out) begin
                    note_failure("pixel mismatch", filtered_q[0], i_out_data);
                    void'(filtered_q.pop_front());
                end else begin
                    void'(filtered_q.pop_front());
                end
            end
            if (i_in_valid && i_in_ready) begin
                take_pixel(i_in_data);
            end
            if (i_cfg_we) begin
                row_windows = i_cfg_wdata;
            end
        end
        o_pending = filtered_q.size();
    end

endmodule

>>> verif/median_mean_blend_3x3_rgb_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_mean_blend_3x3_rgb_core_tb
// Drives pixel bursts and windows_per_row settings into the blend core,
// stalls the output side, and leaves prediction and comparison to the
// checker; gives the verdict from its failure and pending counts.
// ----------------------------------------------------------------------------
module median_mean_blend_3x3_rgb_core_tb;

    localparam int unsigned CH_W           = mmb3_pkg::CH_W;
    localparam int unsigned WPR_W          = mmb3_pkg::WPR_W;
    localparam int unsigned CLK_PERIOD     = 20;
    localparam int unsigned TIMEOUT_CYCLES = 200000;
    localparam int unsigned DRAIN_CYCLES   = 16;
    localparam int unsigned PHASES         = 12;
    localparam int unsigned PHASE_PIXELS   = 34;
    localparam int unsigned RX_ALWAYS      = 0;
    localparam int unsigned RX_RANDOM      = 1;
    localparam int unsigned RX_LONG_STALLS = 2;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    mmb3_pkg::t_pix_in  i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    mmb3_pkg::t_pix_out o_out_data;
    logic               i_cfg_we    = 1'b0;
    logic [WPR_W-1:0]   i_cfg_wdata = '0;

    int unsigned        fail_count;
    int unsigned        pending;
    logic               in_taken    = 1'b0;
    int unsigned        rx_mode     = RX_ALWAYS;
    int unsigned        rx_hold     = 0;

    logic [WPR_W-1:0]   phase_wpr[10] = '{9'd1, 9'd511, 9'd3, 9'd256, 9'd2,
                                          9'd257, 9'd0, 9'd5, 9'd300, 9'd4};

    // Clock
    always begin
        #(CLK_PERIOD/2) i_clk = 1'b1;
        #(CLK_PERIOD/2) i_clk = 1'b0;
    end

    median_mean_blend_3x3_rgb_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    mmb3_blend_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Input beat taken at the last rising edge
    always @(posedge i_clk) begin
        in_taken <= i_in_valid && o_in_ready;
    end

    // Output back-pressure: free running, random, or long stalls
    always @(negedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold     = rx_hold - 1;
            i_out_ready = 1'b0;
        end else if (rx_mode == RX_LONG_STALLS && $urandom_range(0, 15) == 0) begin
            rx_hold     = $urandom_range(5, 20);
            i_out_ready = 1'b0;
        end else if (rx_mode == RX_RANDOM) begin
            i_out_ready = ($urandom_range(0, 9) < 7);
        end else begin
            i_out_ready = 1'b1;
        end
    end

    function automatic mmb3_pkg::t_pix_in make_px(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                                  logic [CH_W-1:0] b);
        mmb3_pkg::t_pix_in px;
        px.red_in   = r;
        px.green_in = g;
        px.blue_in  = b;
        return px;
    endfunction

    // Random channel, weighted towards the extremes
    function automatic logic [CH_W-1:0] rand_chan();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return '1;
        end
        return CH_W'($urandom_range(0, 255));
    endfunction

    // Hold one pixel beat until it is taken; called at a falling edge
    task automatic send_px(mmb3_pkg::t_pix_in px);
        i_in_valid = 1'b1;
        i_in_data  = px;
        do begin
            @(negedge i_clk);
        end while (!in_taken);
    endtask

    // Let every predicted pixel come out, then let the core settle
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_wpr(logic [WPR_W-1:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Watchdog
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus
    initial begin
        int unsigned p;
        int unsigned sent;
        int unsigned burst;
        int unsigned k;
        bit          gappy;

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: full load at the reset row length, then one slid column
        send_px(make_px(8'd0,   8'd0,   8'd0));
        send_px(make_px(8'd255, 8'd255, 8'd255));
        send_px(make_px(8'hAA,  8'h55,  8'h0F));
        send_px(make_px(8'h55,  8'hAA,  8'hF0));
        send_px(make_px(8'd255, 8'd0,   8'd128));
        send_px(make_px(8'd0,   8'd255, 8'd1));
        send_px(make_px(8'd1,   8'd2,   8'd3));
        send_px(make_px(8'd254, 8'd253, 8'd252));
        send_px(make_px(8'd128, 8'd127, 8'd129));
        for (k = 0; k < 3; k++) begin
            send_px(make_px(8'd255, 8'd255, 8'd255));
        end
        wait_idle();

        // zero limit mid-row: next window ends the row, then full loads only
        write_wpr(9'd0);
        for (k = 0; k < 12; k++) begin
            send_px(make_px(8'd255, 8'd255, 8'd255));
        end
        wait_idle();

        // random phases, each under its own row length and output pattern
        for (p = 0; p < PHASES; p++) begin
            write_wpr((p < 10) ? phase_wpr[p] : WPR_W'($urandom_range(0, 511)));
            rx_mode = p % 3;
            sent    = 0;
            while (sent < PHASE_PIXELS) begin
                burst = $urandom_range(1, 12);
                for (k = 0; k < burst && sent < PHASE_PIXELS; k++) begin
                    send_px(make_px(rand_chan(), rand_chan(), rand_chan()));
                    sent++;
                end
                gappy = (p % 4 != 0) && ($urandom_range(0, 3) != 0);
                if (gappy) begin
                    i_in_valid = 1'b0;
                    repeat ($urandom_range(1, 5)) @(negedge i_clk);
                end
            end
            wait_idle();
        end

        // verdict
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/mmb3_pkg.sv
rtl/mmb3_front.sv
rtl/mmb3_queue.sv
rtl/mmb3_back.sv
rtl/median_mean_blend_3x3_rgb_core.sv
verif/mmb3_blend_checker.sv
verif/median_mean_blend_3x3_rgb_core_tb.sv
